FILE: rtl/assert_macros.svh
// assertion macros shared by the sketch rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BKSC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define BKSC_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define BKSC_ASSERT(lbl, clk, rst_n, prop)
`define BKSC_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: rtl/bksc_pkg.sv
// types, constants and helpers for the bottom-k sketch
`timescale 1ns / 1ps
`default_nettype none

package bksc_pkg;

  localparam int IN_HASH_W = 63;
  localparam int HASH_W    = 44;
  localparam int COUNT_W   = 32;
  localparam int SLOT_W    = 6;
  localparam int SLOT_SPAN = 1 << SLOT_W;

  // prime modulus, below 2^44 but above 2^43
  localparam logic [HASH_W-1:0] HASH_PRIME = 44'd9999999999971;

  // quotient estimate: hash bits from 2^43 up times a scaled reciprocal
  localparam int QUOT_LSB = HASH_W - 1;
  localparam int QUOT_W   = IN_HASH_W - QUOT_LSB;
  localparam int RECIP_W  = 24;
  // floor(2^67 / prime)
  localparam logic [RECIP_W-1:0] RECIP = 24'd14757395;

  typedef enum logic {
    OP_ADD,
    OP_READ
  } op_e;

  typedef enum logic [1:0] {
    STAT_IGNORED,
    STAT_COUNTED,
    STAT_INSERTED,
    STAT_READ
  } status_e;

  typedef struct packed {
    op_e                    operation;
    logic [IN_HASH_W-1:0]   hash_value;
    logic [SLOT_W-1:0]      slot_index;
  } in_word_t;

  typedef struct packed {
    status_e                status;
    logic [SLOT_W-1:0]      slot_position;
    logic [HASH_W-1:0]      slot_hash;
    logic [COUNT_W-1:0]     slot_count;
  } out_word_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic inc_en;
  } cell_ctrl_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] r;
    r = (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bottom_k_sketch_with_counts.sv
// top level of the bottom-k sketch with occurrence counts
//
// keeps the SKETCH_SIZE smallest distinct hashes (reduced modulo the prime
// 9999999999971) in ascending order, each with a saturating 32-bit count.
// every input word yields exactly one output word. an add word is first
// reduced in registered steps (a quotient estimate from the hash bits above
// 2^43 times a scaled reciprocal, a multiply-back and subtract, one
// conditional subtract of the prime), then every cell compares its slot
// with the key in parallel, then the row of cells shifts, inserts or
// increments while the result is written. a read word goes straight to
// the update step, where its result is written. one word is worked on at
// a time and the input is free again the cycle after the result is
// written. the result sits in an output register, so the next word is
// taken while the previous result is stalled; a finished word then waits
// in place with the input stalled until the output register drains.
// after reset the table is empty (all-ones hash, zero count) at once.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bottom_k_sketch_with_counts #(
  parameter int SKETCH_SIZE = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bksc_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bksc_pkg::out_word_t out_word_o
);
  import bksc_pkg::*;

  localparam int IDX_W  = (SKETCH_SIZE > 1) ? $clog2(SKETCH_SIZE) : 1;
  localparam int POS_XW = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]        state_q, state_d;
  op_e               op_q;
  logic [SLOT_W-1:0] idx_q;

  logic              in_acc;
  logic              mod_done;
  logic [HASH_W-1:0] key;

  logic              out_valid_q, out_valid_d;
  out_word_t         out_word_q, out_word_d;
  logic              out_load;

  cell_ctrl_t        ctrl;

  // row of cells and the wires between neighbors
  logic [SKETCH_SIZE-1:0] ge_vec, eq_vec, spot_vec, rd_sel, sel;
  logic [HASH_W-1:0]      cell_hash  [SKETCH_SIZE];
  logic [COUNT_W-1:0]     cell_count [SKETCH_SIZE];

  logic [HASH_W-1:0]      sel_hash;
  logic [COUNT_W-1:0]     sel_count;
  logic [IDX_W-1:0]       spot_pos;
  logic [POS_XW-1:0]      spot_pos_x;
  logic                   any_eq, ge_last, rd_hit;

  // ---------------------------------------------------------------- handshake
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // result may be written once the output register is free or draining
  assign out_load = (state_q == ST_UPD) && (!out_valid_q || !out_stall_i);

  // ---------------------------------------------------------------- reduction
  bksc_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && (in_word_i.operation == OP_ADD)),
    .value_i (in_word_i.hash_value),
    .done_o  (mod_done),
    .rem_o   (key)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_word_i.operation == OP_ADD) ? ST_MOD : ST_UPD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // word fields kept for the whole operation
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_word_i.operation;
      idx_q <= in_word_i.slot_index;
    end
  end

  // ---------------------------------------------------------------- cell commands
  // the table is sorted, so the last cell's flag says whether any slot qualifies
  assign ge_last = ge_vec[SKETCH_SIZE-1];
  assign any_eq  = |eq_vec;

  always_comb begin
    ctrl.cmp_en = (state_q == ST_CMP);
    ctrl.inc_en = out_load && (op_q == OP_ADD) && any_eq;
    ctrl.ins_en = out_load && (op_q == OP_ADD) && !any_eq && ge_last;
  end

  // ---------------------------------------------------------------- row of cells
  for (genvar g = 0; g < SKETCH_SIZE; g++) begin : g_cell
    logic               prev_ge;
    logic [HASH_W-1:0]  prev_hash;
    logic [COUNT_W-1:0] prev_count;

    if (g == 0) begin : g_head
      // nothing to the left of the first slot
      assign prev_ge    = 1'b0;
      assign prev_hash  = '1;
      assign prev_count = '0;
    end else begin : g_body
      assign prev_ge    = ge_vec[g-1];
      assign prev_hash  = cell_hash[g-1];
      assign prev_count = cell_count[g-1];
    end

    bksc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (key),
      .prev_ge_i    (prev_ge),
      .prev_hash_i  (prev_hash),
      .prev_count_i (prev_count),
      .ge_o         (ge_vec[g]),
      .eq_o         (eq_vec[g]),
      .spot_o       (spot_vec[g]),
      .hash_o       (cell_hash[g]),
      .count_o      (cell_count[g])
    );

    // reads reach only the slots a 6-bit index can name
    if (g < SLOT_SPAN) begin : g_rd
      assign rd_sel[g] = (idx_q == SLOT_W'(g));
    end else begin : g_nord
      assign rd_sel[g] = 1'b0;
    end
  end

  // ---------------------------------------------------------------- slot select
  assign sel    = (op_q == OP_READ) ? rd_sel : spot_vec;
  assign rd_hit = |rd_sel;

  // one-hot and-or select and position encode over the row
  always_comb begin
    sel_hash  = '0;
    sel_count = '0;
    spot_pos  = '0;
    for (int i = 0; i < SKETCH_SIZE; i++) begin
      sel_hash  = sel_hash  | (cell_hash[i]  & {HASH_W{sel[i]}});
      sel_count = sel_count | (cell_count[i] & {COUNT_W{sel[i]}});
      spot_pos  = spot_pos  | (IDX_W'(i)     & {IDX_W{spot_vec[i]}});
    end
  end

  assign spot_pos_x = POS_XW'(spot_pos);

  // ---------------------------------------------------------------- result word
  always_comb begin
    out_word_d = out_word_q;
    if (op_q == OP_READ) begin
      out_word_d.status        = STAT_READ;
      out_word_d.slot_position = idx_q;
      out_word_d.slot_hash     = rd_hit ? sel_hash : '1;
      out_word_d.slot_count    = rd_hit ? sel_count : '0;
    end else if (any_eq) begin
      out_word_d.status        = STAT_COUNTED;
      out_word_d.slot_position = spot_pos_x[SLOT_W-1:0];
      out_word_d.slot_hash     = key;
      out_word_d.slot_count    = sat_inc(sel_count);
    end else if (ge_last) begin
      out_word_d.status        = STAT_INSERTED;
      out_word_d.slot_position = spot_pos_x[SLOT_W-1:0];
      out_word_d.slot_hash     = key;
      out_word_d.slot_count    = COUNT_W'(1);
    end else begin
      // ranks beyond the table
      out_word_d.status        = STAT_IGNORED;
      out_word_d.slot_position = '0;
      out_word_d.slot_hash     = key;
      out_word_d.slot_count    = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q <= out_word_d;
    end
  end

  // ---------------------------------------------------------------- assertions
  // the reduction only finishes while the sequencer waits for it
  `BKSC_ASSERT(a_mod_done_in_mod, clk_i, rst_ni, mod_done |-> (state_q == ST_MOD))
  // sorted table: at most one cell can be the insertion point
  `BKSC_ASSERT(a_spot_onehot, clk_i, rst_ni, $onehot0(spot_vec))
  // a matching hash can only sit at the insertion point
  `BKSC_NEVER(a_eq_off_spot, clk_i, rst_ni, (eq_vec & ~spot_vec) != '0)
  // a committed update always leaves a result behind
  `BKSC_ASSERT(a_load_gives_valid, clk_i, rst_ni, out_load |=> out_valid_q)

endmodule

`default_nettype wire

FILE: rtl/bksc_mod.sv
// three-step reduction of a 63-bit hash modulo the sketch prime
`timescale 1ns / 1ps
`default_nettype none

module bksc_mod (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bksc_pkg::IN_HASH_W-1:0] value_i,
  output logic                           done_o,
  output logic [bksc_pkg::HASH_W-1:0]    rem_o
);
  import bksc_pkg::*;

  // step codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_QUOT = 2'd1;
  localparam logic [1:0] PH_DIFF = 2'd2;
  localparam logic [1:0] PH_FIX  = 2'd3;

  logic [1:0]                phase_q, phase_d;
  logic [IN_HASH_W-1:0]      val_q, val_d;
  logic [QUOT_W-1:0]         quot_q, quot_d;
  logic [HASH_W:0]           diff_q, diff_d;
  logic [HASH_W-1:0]         rem_q, rem_d;
  logic [QUOT_W+RECIP_W-1:0] quot_prod;
  logic [HASH_W:0]           back_prod;

  // remainder lands at the coming edge
  assign done_o = (phase_q == PH_FIX);
  assign rem_o  = rem_q;

  // estimate never above the true quotient and at most one below it
  assign quot_prod = (QUOT_W+RECIP_W)'(val_q[IN_HASH_W-1:QUOT_LSB]) *
                     (QUOT_W+RECIP_W)'(RECIP);
  // low bits are enough, the difference stays below twice the prime
  assign back_prod = (HASH_W+1)'(quot_q) * (HASH_W+1)'(HASH_PRIME);

  always_comb begin
    phase_d = phase_q;
    val_d   = val_q;
    quot_d  = quot_q;
    diff_d  = diff_q;
    rem_d   = rem_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          val_d   = value_i;
          phase_d = PH_QUOT;
        end
      end
      PH_QUOT: begin
        quot_d  = quot_prod[QUOT_W+RECIP_W-1:RECIP_W];
        phase_d = PH_DIFF;
      end
      PH_DIFF: begin
        diff_d  = val_q[HASH_W:0] - back_prod;
        phase_d = PH_FIX;
      end
      PH_FIX: begin
        if (diff_q >= {1'b0, HASH_PRIME}) begin
          rem_d = HASH_W'(diff_q - {1'b0, HASH_PRIME});
        end else begin
          rem_d = diff_q[HASH_W-1:0];
        end
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    quot_q <= quot_d;
    diff_q <= diff_d;
    rem_q  <= rem_d;
  end

endmodule

`default_nettype wire

FILE: rtl/bksc_cell.sv
// one sketch slot: compare against the key, then hold, take the left neighbor, take the key or bump the count
`timescale 1ns / 1ps
`default_nettype none

module bksc_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bksc_pkg::cell_ctrl_t         ctrl_i,
  input  logic [bksc_pkg::HASH_W-1:0]  key_i,
  input  logic                         prev_ge_i,
  input  logic [bksc_pkg::HASH_W-1:0]  prev_hash_i,
  input  logic [bksc_pkg::COUNT_W-1:0] prev_count_i,
  output logic                         ge_o,
  output logic                         eq_o,
  output logic                         spot_o,
  output logic [bksc_pkg::HASH_W-1:0]  hash_o,
  output logic [bksc_pkg::COUNT_W-1:0] count_o
);
  import bksc_pkg::*;

  logic [HASH_W-1:0]  hash_q, hash_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               ge_q, ge_d;
  logic               eq_q, eq_d;

  // first cell not below the key
  assign spot_o  = ge_q && !prev_ge_i;
  assign ge_o    = ge_q;
  assign eq_o    = eq_q;
  assign hash_o  = hash_q;
  assign count_o = count_q;

  always_comb begin
    hash_d  = hash_q;
    count_d = count_q;
    ge_d    = ge_q;
    eq_d    = eq_q;
    if (ctrl_i.cmp_en) begin
      ge_d = (hash_q >= key_i);
      eq_d = (hash_q == key_i);
    end
    if (ctrl_i.ins_en) begin
      if (prev_ge_i) begin
        hash_d  = prev_hash_i;
        count_d = prev_count_i;
      end else if (ge_q) begin
        hash_d  = key_i;
        count_d = COUNT_W'(1);
      end
    end
    if (ctrl_i.inc_en && eq_q) begin
      count_d = sat_inc(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= '1;
      count_q <= '0;
      ge_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      hash_q  <= hash_d;
      count_q <= count_d;
      ge_q    <= ge_d;
      eq_q    <= eq_d;
    end
  end

endmodule

`default_nettype wire

FILE: verif/bksc_sketch_checker.sv
// checker for the bottom-k sketch: predicts each result word and compares it
`timescale 1ns / 1ps
module bksc_sketch_checker #(
  parameter int SKETCH_SIZE = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  bksc_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  bksc_pkg::out_word_t out_word_i,
  output int                  mismatches_o,
  output int                  pending_o
);
  import bksc_pkg::*;

  logic [HASH_W-1:0]  sketch_hash  [SKETCH_SIZE];
  logic [COUNT_W-1:0] sketch_count [SKETCH_SIZE];
  out_word_t          due_words    [$];
  out_word_t          want;
  int                 mismatch_count = 0;

  // one word through the sketch, returns the result word it should give
  function automatic out_word_t apply_to_sketch(input in_word_t w);
    out_word_t         r;
    logic [HASH_W-1:0] key;
    int                slot;
    int                i;
    r.status        = STAT_READ;
    r.slot_position = w.slot_index;
    r.slot_hash     = '1;
    r.slot_count    = '0;
    if (w.operation == OP_READ) begin
      if (int'(w.slot_index) < SKETCH_SIZE) begin
        r.slot_hash  = sketch_hash[w.slot_index];
        r.slot_count = sketch_count[w.slot_index];
      end
      return r;
    end
    key = HASH_W'({1'b0, w.hash_value} % {20'd0, HASH_PRIME});
    // lowest slot whose hash is not below the key
    slot = SKETCH_SIZE;
    for (i = SKETCH_SIZE - 1; i >= 0; i--)
      if (sketch_hash[i] >= key) slot = i;
    r.slot_hash = key;
    if (slot == SKETCH_SIZE) begin
      r.status        = STAT_IGNORED;
      r.slot_position = '0;
    end else if (sketch_hash[slot] == key) begin
      if (sketch_count[slot] != '1) sketch_count[slot] = sketch_count[slot] + 1'b1;
      r.status        = STAT_COUNTED;
      r.slot_position = SLOT_W'(slot);
      r.slot_count    = sketch_count[slot];
    end else begin
      for (i = SKETCH_SIZE - 1; i > slot; i--) begin
        sketch_hash[i]  = sketch_hash[i-1];
        sketch_count[i] = sketch_count[i-1];
      end
      sketch_hash[slot]  = key;
      sketch_count[slot] = COUNT_W'(1);
      r.status           = STAT_INSERTED;
      r.slot_position    = SLOT_W'(slot);
      r.slot_count       = COUNT_W'(1);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SKETCH_SIZE; i++) begin
        sketch_hash[i]  = '1;
        sketch_count[i] = '0;
      end
      due_words.delete();
    end else begin
      // results first, so a stray result never meets a word taken this edge
      if (out_valid_i && !out_stall_i) begin
        if (due_words.size() == 0) begin
          $error("result word with no prediction pending");
          mismatch_count++;
        end else begin
          want = due_words.pop_front();
          if (out_word_i.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_word_i.status);
            mismatch_count++;
          end
          if (out_word_i.slot_position !== want.slot_position) begin
            $error("slot_position expected %0d got %0d", want.slot_position,
                   out_word_i.slot_position);
            mismatch_count++;
          end
          if (out_word_i.slot_hash !== want.slot_hash) begin
            $error("slot_hash expected %h got %h", want.slot_hash, out_word_i.slot_hash);
            mismatch_count++;
          end
          if (out_word_i.slot_count !== want.slot_count) begin
            $error("slot_count expected %0d got %0d", want.slot_count,
                   out_word_i.slot_count);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) due_words.push_back(apply_to_sketch(in_word_i));
    end
    pending_o    <= due_words.size();
    mismatches_o <= mismatch_count;
  end

endmodule

FILE: verif/tb_bottom_k_sketch_with_counts.sv
// testbench top for the bottom-k sketch: makes the word stream and gives the verdict
`timescale 1ns / 1ps
module tb_bottom_k_sketch_with_counts;
  import bksc_pkg::*;

  localparam int SKETCH_SIZE  = 64;
  localparam int RANDOM_WORDS = 1900;
  localparam int IDLE_PCT     = 28;
  localparam int HOLD_CYCLES  = 300;
  // largest multiple of the prime that still fits in 63 bits with any key added
  localparam int unsigned MAX_MULTIPLE = 922336;
  localparam logic [63:0] PRIME64      = 64'(HASH_PRIME);

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  int        mismatches;
  int        pending;

  // quiet stretch: neither side idles while this is set
  bit        calm      = 1'b0;
  // asks the result side for one long hold-off
  bit        hold_req  = 1'b0;

  // keys believed to sit in the sketch, ascending, used only to aim stimulus
  logic [63:0] kept_keys [$];

  bottom_k_sketch_with_counts #(
    .SKETCH_SIZE(SKETCH_SIZE)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  bksc_sketch_checker #(
    .SKETCH_SIZE(SKETCH_SIZE)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        // the sketch and its output register fill up and in_stall rises
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // track a key in the aimed copy: sorted, distinct, no deeper than the sketch
  function automatic void note_key(input logic [63:0] key);
    int at;
    int i;
    at = -1;
    for (i = 0; i < kept_keys.size(); i++)
      if (at < 0 && kept_keys[i] >= key) at = i;
    if (at < 0) kept_keys.push_back(key);
    else if (kept_keys[at] != key) kept_keys.insert(at, key);
    if (kept_keys.size() > SKETCH_SIZE) void'(kept_keys.pop_back());
  endfunction

  // offer one word, with an occasional idle gap in front, and wait until taken
  task automatic push_word(input in_word_t w);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic send_add(input logic [62:0] raw);
    in_word_t w;
    w.operation  = OP_ADD;
    w.hash_value = raw;
    w.slot_index = SLOT_W'($urandom);
    note_key(64'(raw) % PRIME64);
    push_word(w);
  endtask

  task automatic send_read(input logic [SLOT_W-1:0] slot);
    in_word_t w;
    w.operation  = OP_READ;
    w.hash_value = IN_HASH_W'(rand64());
    w.slot_index = slot;
    push_word(w);
  endtask

  // let every predicted result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // one random word: mostly aimed keys, some reads, a little raw noise
  task automatic pick_word(output in_word_t w);
    logic [63:0] key;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] tail;
    int unsigned roll;
    int          i;
    bit          aimed;
    w.operation  = OP_ADD;
    w.hash_value = IN_HASH_W'(rand64());
    w.slot_index = SLOT_W'($urandom);
    aimed  = 1'b1;
    key    = '0;
    roll   = $urandom_range(99);
    if (roll < 25) begin
      w.operation = OP_READ;
      aimed       = 1'b0;
    end else if (roll >= 88) begin
      // raw noise over the whole 63-bit range
      aimed  = 1'b0;
      note_key(64'(w.hash_value) % PRIME64);
    end else if (kept_keys.size() == 0) begin
      key = rand64() % PRIME64;
    end else if (roll < 45) begin
      // repeat a kept key: count goes up somewhere along the table
      key = kept_keys[$urandom_range(kept_keys.size() - 1)];
    end else if (roll < 65 && kept_keys.size() > 1) begin
      // fall into a gap between two kept keys: insert in the middle
      i  = $urandom_range(kept_keys.size() - 1, 1);
      lo = kept_keys[i-1];
      hi = kept_keys[i];
      key = (hi - lo > 1) ? lo + 1 + rand64() % (hi - lo - 1) : hi;
    end else if (roll < 75 && kept_keys[0] != 0) begin
      // below the head: insert at slot 0
      key = rand64() % kept_keys[0];
    end else begin
      // just past the tail: insert at the end, or dropped once the sketch is full
      tail   = kept_keys[$];
      key    = (tail == PRIME64 - 1) ? tail : tail + 1 + rand64() % (PRIME64 - 1 - tail);
    end
    if (aimed) begin
      note_key(key);
      // same key under a random multiple of the prime, so the modulo is exercised
      w.hash_value = IN_HASH_W'(key + 64'($urandom_range(MAX_MULTIPLE)) * PRIME64);
    end
  endtask

  initial begin
    in_word_t    w;
    int unsigned n;
    int          i;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty reads, key extremes, the prime itself, bit patterns
    send_read('0);
    send_read('1);
    send_add('0);
    send_add(IN_HASH_W'(HASH_PRIME));               // reduces to zero, counts up
    send_add('1);
    send_add(IN_HASH_W'(HASH_PRIME) - 1'b1);        // largest key
    send_add(IN_HASH_W'(PRIME64 * 2 - 1));          // same largest key again
    send_add(IN_HASH_W'(1));
    send_add(IN_HASH_W'(PRIME64 + 1));              // repeat of key one
    send_add(63'h5555_5555_5555_5555);
    send_add(63'h2AAA_AAAA_AAAA_AAAA);
    send_add(IN_HASH_W'(44'hFFF_FFFF_FFFF));
    send_add(IN_HASH_W'(1) << 43);
    for (i = 0; i < 6; i++) send_read(SLOT_W'(i));
    send_read(6'h2A);
    send_read(6'h15);
    send_read('1);
    wait_drained();

    // random part: mostly aimed keys, some reads, a little raw noise
    n = 0;
    while (n < RANDOM_WORDS) begin
      calm = (n >= 700 && n < 1000);
      if (n == 400) hold_req = 1'b1;
      if (n == 1300) wait_drained();
      pick_word(w);
      push_word(w);
      n++;
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
